### sv/lnn_pkg.sv
// Shared types and constants for the leave-one-out nearest neighbor core.
// No dependencies; imported by the core and used for parameter defaults.
`default_nettype none
package lnn_pkg;

    localparam int DEF_MAX_ROWS     = 1024;
    localparam int DEF_MAX_FEATURES = 64;
    localparam int DEF_VALUE_BITS   = 16;

    // Saturation width of the per-pair distance sum
    localparam int DIST_W = 40;
    // Result field width
    localparam int OUT_W  = 11;
    // Mask register width and the feature_count register width
    localparam int MASK_W = 64;
    localparam int FCNT_W = 7;
    localparam int CFG_W  = 64;

    typedef enum logic [1:0] {
        CMD_ROW     = 2'd0,
        CMD_FEATURE = 2'd1,
        CMD_EVAL    = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    // Register select is paddr bit 3 (registers at byte 0 and byte 8)
    localparam logic REG_MASK  = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    // Tags carried along the distance pipeline
    typedef struct packed {
        logic valid;
        logic masked;
        logic first_k;
        logic last_k;
        logic first_j;
        logic last_j;
    } tag_t;

endpackage
`default_nettype wire

### sv/leave_one_out_nearest_neighbor_core.sv
// Leave-one-out nearest neighbor core: dataset load, evaluation sequencer,
// distance pipeline and APB register file. Depends on lnn_pkg and lnn_ram.
//
//  channel   dir  signals                           contents
//  s_*       in   s_tvalid s_tready s_tdata s_tuser command (tuser), value (tdata)
//  m_*       out  m_tvalid m_tready m_tdata          correct_count, total_rows
//  APB       in   psel penable pwrite paddr pwdata   feature_mask @0, feature_count @8
//
// Load items (row start, feature, clear) are accepted back to back while idle.
// Evaluate steps through N*(N-1) row pairs for N stored rows and max(nf,1) feature
// slots per pair for nf active features: the feature memory delivers one feature pair per cycle.
// While evaluating, s_tready is low; a pending result only holds the next
// evaluate. Reset clears control state; the memories are not cleared.
`default_nettype none
module leave_one_out_nearest_neighbor_core
    import lnn_pkg::*;
#(
    parameter int MAX_ROWS     = DEF_MAX_ROWS,
    parameter int MAX_FEATURES = DEF_MAX_FEATURES,
    parameter int VALUE_BITS   = DEF_VALUE_BITS
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // [VALUE_BITS-1:0] value, rest zero
    input  wire logic [((VALUE_BITS+7)/8)*8-1:0]        s_tdata,
    // [1:0] command
    input  wire logic [1:0]                             s_tuser,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // [10:0] correct_count, [21:11] total_rows, [23:22] zero
    output logic [23:0]                                 m_tdata,
    input  wire logic                                   psel,
    input  wire logic                                   penable,
    input  wire logic                                   pwrite,
    input  wire logic [3:0]                             paddr,
    input  wire logic [CFG_W-1:0]                       pwdata,
    output logic [CFG_W-1:0]                            prdata,
    output logic                                        pready
);

    localparam int ROW_W     = $clog2(MAX_ROWS + 1);
    localparam int ROW_IDX_W = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_FEATURES + 1);
    localparam int FDEPTH    = MAX_ROWS * MAX_FEATURES;
    localparam int ADDR_W    = $clog2(FDEPTH);
    localparam int VB        = VALUE_BITS;
    localparam int SQ_W      = 2 * VB + 2;
    localparam int SUM_W     = ((SQ_W > DIST_W) ? SQ_W : DIST_W) + 1;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_DONE} state_t;

    state_t                state_reg;
    logic [MASK_W-1:0]     mask_reg;
    logic [FCNT_W-1:0]     fcnt_reg;
    logic [ROW_W-1:0]      rows_reg;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_IDX_W-1:0]  i_reg;
    logic [ROW_IDX_W-1:0]  j_reg;
    logic [COL_W-1:0]      k_reg;
    tag_t                  p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [VB:0]    diff_reg;
    logic [SQ_W-1:0]       sq_reg;
    logic [DIST_W-1:0]     acc_reg;
    logic [DIST_W-1:0]     best_reg;
    logic [7:0]            blabel_reg;
    logic [7:0]            li1_reg, lj1_reg, li2_reg, lj2_reg, li3_reg, lj3_reg;
    logic [ROW_W-1:0]      tally_reg;
    logic                  m_tvalid_reg;
    logic [23:0]           m_tdata_reg;

    cmd_t                  cmd;
    logic                  in_xfer;
    logic [COL_W-1:0]      nf;
    logic [COL_W-1:0]      k_last;
    logic [ROW_IDX_W-1:0]  j_last;
    logic                  last_k, last_j, last_i;
    logic                  issue_masked;
    logic [5:0]            mask_sel;
    logic                  feat_we, label_we;
    logic [ADDR_W-1:0]     feat_waddr, feat_raddr_a, feat_raddr_b;
    logic [VB-1:0]         feat_a, feat_b;
    logic [7:0]            label_a, label_b;
    logic [SUM_W-1:0]      sum_wide;
    logic [DIST_W-1:0]     acc_base, acc_next;
    logic                  take;
    logic [DIST_W-1:0]     best_next;
    logic [7:0]            blabel_next;
    logic signed [SQ_W-1:0] sq_full;
    tag_t                  p0_next;
    logic                  result_load;

    assign cmd      = cmd_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;

    // Register readback
    always_comb
    begin
        case (paddr[3])
            REG_MASK:  prdata = mask_reg;
            REG_COUNT: prdata = CFG_W'(fcnt_reg);
            default:   prdata = '0;
        endcase
    end

    // Active feature count, clamped to capacity
    assign nf       = (fcnt_reg > FCNT_W'(MAX_FEATURES)) ? COL_W'(MAX_FEATURES)
                                                         : COL_W'(fcnt_reg);
    assign k_last   = (nf == '0) ? '0 : nf - 1'b1;
    assign last_k   = (k_reg == k_last);
    assign last_i   = (ROW_W'(i_reg) == rows_reg - 1'b1);
    assign j_last   = last_i ? ROW_IDX_W'(rows_reg - 2'd2) : ROW_IDX_W'(rows_reg - 1'b1);
    assign last_j   = (j_reg == j_last);
    assign mask_sel = 6'(k_reg);
    assign issue_masked = (k_reg >= nf) || !mask_reg[mask_sel];

    // Issue tags for the pair fetched this cycle
    always_comb
    begin
        p0_next = '0;
        if (state_reg == ST_RUN)
        begin
            p0_next.valid   = 1'b1;
            p0_next.masked  = issue_masked;
            p0_next.first_k = (k_reg == '0);
            p0_next.last_k  = last_k;
            p0_next.first_j = (j_reg == ((i_reg == '0) ? ROW_IDX_W'(1) : '0));
            p0_next.last_j  = last_j;
        end
    end

    // Memory ports: writes only while loading; read addresses follow the evaluation counters
    assign feat_we    = in_xfer && (cmd == CMD_FEATURE) && (rows_reg != '0) && (col_reg < nf);
    assign label_we   = in_xfer && (cmd == CMD_ROW) && (rows_reg < ROW_W'(MAX_ROWS));
    assign feat_waddr = ADDR_W'(rows_reg - 1'b1) * ADDR_W'(MAX_FEATURES) + ADDR_W'(col_reg);
    assign feat_raddr_a = ADDR_W'(i_reg) * ADDR_W'(MAX_FEATURES) + ADDR_W'(k_reg);
    assign feat_raddr_b = ADDR_W'(j_reg) * ADDR_W'(MAX_FEATURES) + ADDR_W'(k_reg);

    lnn_ram #(.WIDTH(VB), .DEPTH(FDEPTH)) u_feat_ram (
        .clk     (clk),
        .we      (feat_we),
        .waddr   (feat_waddr),
        .wdata   (s_tdata[VB-1:0]),
        .raddr_a (feat_raddr_a),
        .rdata_a (feat_a),
        .raddr_b (feat_raddr_b),
        .rdata_b (feat_b)
    );

    lnn_ram #(.WIDTH(8), .DEPTH(MAX_ROWS)) u_label_ram (
        .clk     (clk),
        .we      (label_we),
        .waddr   (ROW_IDX_W'(rows_reg)),
        .wdata   (s_tdata[7:0]),
        .raddr_a (i_reg),
        .rdata_a (label_a),
        .raddr_b (j_reg),
        .rdata_b (label_b)
    );

    // Square of the feature difference, full width
    assign sq_full = diff_reg * diff_reg;

    // Saturating accumulate
    assign acc_base = p2_reg.first_k ? '0 : acc_reg;
    assign sum_wide = SUM_W'(acc_base) + SUM_W'(sq_reg);
    assign acc_next = (sum_wide >= SUM_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum_wide);

    // Nearest candidate update; first candidate always taken, ties keep earlier
    assign take        = p3_reg.first_j || (acc_reg < best_reg);
    assign best_next   = take ? acc_reg : best_reg;
    assign blabel_next = take ? lj3_reg : blabel_reg;

    // Result register loads in the done state when the output slot is free
    assign result_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Datapath pipeline (no reset needed on payload)
    always_ff @(posedge clk)
    begin
        li1_reg  <= label_a;
        lj1_reg  <= label_b;
        diff_reg <= p0_reg.masked ? '0
                  : $signed({feat_a[VB-1], feat_a}) - $signed({feat_b[VB-1], feat_b});
        li2_reg  <= li1_reg;
        lj2_reg  <= lj1_reg;
        sq_reg   <= $unsigned(sq_full);
        if (p2_reg.valid)
        begin
            acc_reg <= acc_next;
            li3_reg <= li2_reg;
            lj3_reg <= lj2_reg;
        end
    end

    // Control, load state, sequencer and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            mask_reg     <= '1;
            fcnt_reg     <= FCNT_W'(64);
            rows_reg     <= '0;
            col_reg      <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            p0_reg       <= '0;
            p1_reg       <= '0;
            p2_reg       <= '0;
            p3_reg       <= '0;
            best_reg     <= DIST_MAX;
            blabel_reg   <= '0;
            tally_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            // Configuration writes
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3])
                    REG_MASK:  mask_reg <= pwdata;
                    REG_COUNT: fcnt_reg <= pwdata[FCNT_W-1:0];
                    default:   mask_reg <= mask_reg;
                endcase
            end

            // Output register
            if (result_load)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {2'b00, OUT_W'(rows_reg), OUT_W'(tally_reg)};
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            // Pipeline tags
            p0_reg       <= p0_next;
            p1_reg       <= p0_reg;
            p2_reg       <= p1_reg;
            p3_reg       <= (p2_reg.valid && p2_reg.last_k) ? p2_reg : '0;

            // Candidate compare and tally
            if (p3_reg.valid)
            begin
                best_reg   <= best_next;
                blabel_reg <= blabel_next;
                if (p3_reg.last_j && (blabel_next == li3_reg))
                begin
                    tally_reg <= tally_reg + 1'b1;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        case (cmd)
                            CMD_ROW:
                            begin
                                if (rows_reg < ROW_W'(MAX_ROWS))
                                begin
                                    rows_reg <= rows_reg + 1'b1;
                                    col_reg  <= '0;
                                end
                                else
                                begin
                                    col_reg <= COL_W'(MAX_FEATURES);
                                end
                            end
                            CMD_FEATURE:
                            begin
                                if (feat_we)
                                begin
                                    col_reg <= col_reg + 1'b1;
                                end
                            end
                            CMD_EVAL:
                            begin
                                tally_reg <= '0;
                                i_reg     <= '0;
                                j_reg     <= ROW_IDX_W'(1);
                                k_reg     <= '0;
                                state_reg <= (rows_reg < ROW_W'(2)) ? ST_DONE : ST_RUN;
                            end
                            CMD_CLEAR:
                            begin
                                rows_reg <= '0;
                                col_reg  <= '0;
                            end
                            default:
                            begin
                                rows_reg <= rows_reg;
                            end
                        endcase
                    end
                end
                ST_RUN:
                begin
                    if (!last_k)
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                    else
                    begin
                        k_reg <= '0;
                        if (!last_j)
                        begin
                            j_reg <= (j_reg + 1'b1 == i_reg) ? j_reg + 2'd2 : j_reg + 1'b1;
                        end
                        else if (!last_i)
                        begin
                            i_reg <= i_reg + 1'b1;
                            j_reg <= '0;
                        end
                        else
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (!p0_reg.valid && !p1_reg.valid && !p2_reg.valid && !p3_reg.valid)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (result_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Checks
    a_rows_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg <= ROW_W'(MAX_ROWS))
        else $error("stored row count beyond capacity");

    a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (tally_reg <= rows_reg))
        else $error("match tally exceeds row count");

    a_pair_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        p3_reg.valid |-> (state_reg == ST_DRAIN || state_reg == ST_RUN))
        else $error("pair result outside evaluation");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    a_no_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |=> !p0_reg.valid)
        else $error("pipeline issue while idle");

endmodule
`default_nettype wire

### sv/lnn_ram.sv
// Generic simple RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none
module lnn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered reads
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

### sim/tb.sv
// Testbench for leave_one_out_nearest_neighbor_core: loads labeled rows, runs
// evaluations and checks each accuracy tally against an in-bench predictor.
// Depends on lnn_pkg and the core RTL.
`timescale 1ns / 100ps
module tb
    import lnn_pkg::*;
;

    localparam int ROWS_CAP  = 1024;
    localparam int FEAT_CAP  = 64;
    localparam longint DIST_SAT = (64'd1 << DIST_W) - 1;
    localparam int CYCLE_LIMIT = 6000000;
    localparam logic [3:0] ADDR_MASK  = 4'd0;
    localparam logic [3:0] ADDR_COUNT = 4'd8;

    typedef struct packed {
        logic [10:0] correct;
        logic [10:0] total;
    } tally_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [15:0] value
    logic [1:0]  s_tuser;   // [1:0] command
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [10:0] correct_count, [21:11] total_rows
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    // Predictor state
    logic [15:0] feat_mem [0:ROWS_CAP-1][0:FEAT_CAP-1];
    bit          feat_written [0:ROWS_CAP-1][0:FEAT_CAP-1];
    logic [7:0]  label_mem [0:ROWS_CAP-1];
    int          row_total;
    int          open_col;
    logic [63:0] mask_reg;
    logic [6:0]  count_reg;

    tally_t expected_tallies[$];
    int     mismatches;
    int     hold_cycles;
    bit     quiet;
    longint cycles;

    leave_one_out_nearest_neighbor_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int active_nf();
        return (count_reg > FEAT_CAP) ? FEAT_CAP : int'(count_reg);
    endfunction

    // Squared distance between two rows, saturating
    function automatic longint row_distance(int a, int b, int nf);
        longint sum;
        longint sq;
        int diff;
        sum = 0;
        for (int k = 0; k < nf; k++)
        begin
            if (!mask_reg[k])
                continue;
            diff = int'($signed(feat_mem[a][k])) - int'($signed(feat_mem[b][k]));
            sq = longint'(diff) * longint'(diff);
            if (sq >= DIST_SAT || sum >= DIST_SAT - sq)
                sum = DIST_SAT;
            else
                sum += sq;
        end
        return sum;
    endfunction

    function automatic int count_matches();
        int nf;
        int hits;
        bit found;
        longint best;
        longint d;
        logic [7:0] best_lab;
        nf = active_nf();
        hits = 0;
        for (int i = 0; i < row_total; i++)
        begin
            found = 0;
            best = DIST_SAT;
            best_lab = 8'd0;
            for (int j = 0; j < row_total; j++)
            begin
                if (j == i)
                    continue;
                d = row_distance(i, j, nf);
                if (!found || d < best)
                begin
                    found = 1;
                    best = d;
                    best_lab = label_mem[j];
                end
            end
            if (found && best_lab == label_mem[i])
                hits++;
        end
        return hits;
    endfunction

    // Update the predictor with one accepted transfer
    task automatic predict_item(cmd_t c, logic [15:0] v);
        tally_t t;
        case (c)
            CMD_ROW:
                if (row_total < ROWS_CAP)
                begin
                    label_mem[row_total] = v[7:0];
                    row_total++;
                    open_col = 0;
                end
                else
                    open_col = FEAT_CAP;
            CMD_FEATURE:
                if (row_total > 0 && open_col < active_nf())
                begin
                    feat_mem[row_total-1][open_col] = v;
                    feat_written[row_total-1][open_col] = 1;
                    open_col++;
                end
            CMD_EVAL:
            begin
                t.correct = 11'(count_matches());
                t.total = 11'(row_total);
                expected_tallies = {expected_tallies, t};
            end
            default:
            begin
                row_total = 0;
                open_col = 0;
            end
        endcase
    endtask

    // Send one item, with an occasional idle burst ahead of it
    task automatic send_item(cmd_t c, logic [15:0] v);
        int gap;
        gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c;
        s_tdata <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_item(c, v);
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for every result, then let the load pipeline settle
    task automatic wait_idle();
        stop_sending();
        wait (expected_tallies.size() == 0);
        repeat (10) @(posedge clk);
    endtask

    task automatic reg_write(logic [3:0] addr, logic [63:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_MASK)
            mask_reg = data;
        else
            count_reg = data[6:0];
    endtask

    task automatic set_config(logic [6:0] nf, logic [63:0] m);
        wait_idle();
        reg_write(ADDR_COUNT, {57'd0, nf});
        reg_write(ADDR_MASK, m);
    endtask

    function automatic logic [15:0] rand_feature(bit narrow);
        if (narrow)
            return 16'($signed($urandom_range(0, 8)) - 4);
        return 16'($urandom);
    endfunction

    // Load one row; broken rows may skip slots that already hold data
    task automatic put_row(logic [7:0] lab, bit broken, bit narrow);
        int nf;
        int need;
        int supply;
        int r;
        send_item(CMD_ROW, {8'($urandom_range(0, 255)), lab});
        nf = active_nf();
        r = row_total - 1;
        need = nf;
        while (need > 0 && feat_written[r][need-1])
            need--;
        supply = broken ? $urandom_range(need, nf + 3) : nf;
        for (int k = 0; k < supply; k++)
            send_item(CMD_FEATURE, rand_feature(narrow));
    endtask

    // One data set: clear, rows, evaluate
    task automatic run_set(int max_rows);
        int n;
        bit narrow;
        narrow = $urandom_range(0, 1);
        send_item(CMD_CLEAR, 16'($urandom));
        if ($urandom_range(0, 3) == 0)
            send_item(CMD_FEATURE, 16'($urandom));
        n = $urandom_range(0, max_rows);
        for (int r = 0; r < n; r++)
            put_row(8'($urandom_range(0, 3)), $urandom_range(0, 7) == 0, narrow);
        send_item(CMD_EVAL, 16'($urandom));
        if ($urandom_range(0, 5) == 0)
            send_item(CMD_EVAL, 16'($urandom));
    endtask

    // Receiver: random stalls, long hold-off on request
    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                stall = $urandom_range(1, 16);
                repeat (stall - 1) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Result check
    always @(posedge clk)
    begin
        tally_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_tallies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end
            else
            begin
                want = expected_tallies.pop_front();
                if (m_tdata[10:0] !== want.correct || m_tdata[21:11] !== want.total)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tally mismatch: expected correct=%0d total=%0d, got %0d %0d",
                                 want.correct, want.total, m_tdata[10:0], m_tdata[21:11]);
                end
            end
        end
    end

    // Extremes, empty and lone-row sets, dropped features
    task automatic test_directed();
        set_config(7'd2, '1);
        send_item(CMD_EVAL, 16'h0000);
        send_item(CMD_FEATURE, 16'h1234);
        send_item(CMD_ROW, 16'hFF05);
        send_item(CMD_FEATURE, 16'h7FFF);
        send_item(CMD_FEATURE, 16'h8000);
        send_item(CMD_EVAL, 16'hFFFF);
        send_item(CMD_ROW, 16'h0005);
        send_item(CMD_FEATURE, 16'h8000);
        send_item(CMD_FEATURE, 16'h7FFF);
        send_item(CMD_FEATURE, 16'h5555);
        send_item(CMD_ROW, 16'h00FF);
        send_item(CMD_FEATURE, 16'h0000);
        send_item(CMD_FEATURE, 16'hFFFF);
        send_item(CMD_EVAL, 16'h0000);
        send_item(CMD_CLEAR, 16'hAAAA);
        send_item(CMD_FEATURE, 16'h0001);
        send_item(CMD_EVAL, 16'h0000);
    endtask

    // Fill past capacity; a zero mask keeps every distance at zero
    task automatic test_capacity();
        set_config(7'd1, 64'd0);
        send_item(CMD_CLEAR, 16'd0);
        for (int r = 0; r < ROWS_CAP + 2; r++)
        begin
            send_item(CMD_ROW, 16'($urandom_range(0, 3) == 0 ? 3 : 7));
            if (r >= ROWS_CAP)
                send_item(CMD_FEATURE, 16'($urandom));
        end
        send_item(CMD_EVAL, 16'd0);
        send_item(CMD_CLEAR, 16'd0);
    endtask

    task automatic test_random_phases();
        logic [6:0] nf;
        logic [63:0] m;
        for (int p = 0; p < 8; p++)
        begin
            case (p % 4)
                0: nf = 7'd1;
                1: nf = 7'd64;
                default: nf = 7'($urandom_range(2, 10));
            endcase
            case ($urandom_range(0, 3))
                0: m = '1;
                1: m = (p == 5) ? 64'd0 : {$urandom, $urandom};
                default: m = {$urandom, $urandom};
            endcase
            set_config(nf, m);
            for (int s = 0; s < 3; s++)
                run_set(nf > 16 ? 2 : 8);
        end
    endtask

    // Hold the receiver off while evaluates pile up
    task automatic test_backpressure();
        set_config(7'd3, '1);
        hold_cycles = 800;
        for (int s = 0; s < 4; s++)
            run_set(4);
    endtask

    task automatic test_quiet_tail();
        set_config(7'd4, {$urandom, $urandom});
        quiet = 1;
        for (int s = 0; s < 6; s++)
            run_set(6);
        wait_idle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_ROW;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cycles = 0;
        mismatches = 0;
        hold_cycles = 0;
        quiet = 0;
        row_total = 0;
        open_col = 0;
        mask_reg = '1;
        count_reg = 7'd64;
        for (int r = 0; r < ROWS_CAP; r++)
            for (int k = 0; k < FEAT_CAP; k++)
                feat_written[r][k] = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_phases();
        test_backpressure();
        test_capacity();
        test_quiet_tail();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
